[sv/gbf_pkg.sv]
// Package for the graph bridge finder: sizes, opcodes, search states,
// the adjacency memory request struct and bit-vector helper functions.
// No dependencies.
package gbf_pkg;

	localparam int MAX_NODES    = 64;
	localparam int IDX_W        = $clog2(MAX_NODES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int ROW_W        = 2 * MAX_NODES;
	localparam int BRIDGE_LIMIT = 63;
	localparam int BR_W         = 6;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROW_RD,
		S_ROW_WT,
		S_PICK,
		S_REP,
		S_BFS_SEL,
		S_BFS_MRG,
		S_OUT_CNT,
		S_OUT_BR
	} search_state_t;

	// One access to the adjacency memory. Each row holds the adjacency bits
	// in the low half and the per-run reported-pair bits in the high half.
	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [ROW_W-1:0] wdata;
	} adj_req_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [IDX_W-1:0] lowest_bit(input logic [MAX_NODES-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int k = MAX_NODES - 1; k >= 0; k--) begin
			if (v[k]) begin
				r = IDX_W'(k);
			end
		end
		return r;
	endfunction

	// One bit for each node number below n.
	function automatic logic [MAX_NODES-1:0] node_mask(input logic [CNT_W-1:0] n);
		logic [MAX_NODES-1:0] m;
		m = '0;
		for (int k = 0; k < MAX_NODES; k++) begin
			m[k] = (CNT_W'(k) < n);
		end
		return m;
	endfunction

endpackage

[sv/gbf_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a read of the entry being written
	// returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/gbf_search.sv]
// Bridge search sequencer: walks every edge of the adjacency memory, runs up to two
// reachability sweeps per edge and keeps the bridges in a list memory.
// Depends on gbf_pkg and gbf_ram.
module gbf_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gbf_pkg::CNT_W-1:0]    n_eff,
	output gbf_pkg::adj_req_t            adj_req,
	input  logic [gbf_pkg::ROW_W-1:0]    adj_rdata,
	output logic                         busy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         is_bridge,
	output logic [gbf_pkg::BR_W-1:0]     bridge_count,
	output logic [gbf_pkg::IDX_W-1:0]    end_a,
	output logic [gbf_pkg::IDX_W-1:0]    end_b,
	output logic                         last
);

	localparam int N  = gbf_pkg::MAX_NODES;
	localparam int IW = gbf_pkg::IDX_W;
	localparam int BW = gbf_pkg::BR_W;

	gbf_pkg::search_state_t state_q, state_d;

	logic [gbf_pkg::CNT_W-1:0] i_q, i_d;
	logic [IW-1:0] j_q, j_d, x_q, x_d, tgt_q, tgt_d;
	logic [N-1:0]  pend_q, pend_d, row_q, row_d, rep_q, rep_d;
	logic [N-1:0]  reach_q, reach_d, front_q, front_d;
	logic          ph2_q, ph2_d;
	logic [BW-1:0] found_q, found_d, k_q, k_d;

	logic [IW-1:0]   i_idx, jn, xn;
	logic [N-1:0]    mask, row_m, nb;
	logic            list_we, list_re;
	logic [BW-1:0]   list_raddr;
	logic [2*IW-1:0] list_rdata;
	logic            bfs_done, bfs_hit, br_last;

	assign i_idx   = i_q[IW-1:0];
	assign mask    = gbf_pkg::node_mask(n_eff);
	assign row_m   = adj_rdata[N-1:0] & mask;
	assign br_last = (k_q == found_q - BW'(1));

	// Bridge list, filled during the search and read back for the results.
	gbf_ram #(
		.WIDTH(2 * IW),
		.DEPTH(N)
	) u_list (
		.clk  (clk),
		.we   (list_we),
		.waddr(found_q),
		.wdata({i_idx, j_q}),
		.re   (list_re),
		.raddr(list_raddr),
		.rdata(list_rdata)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers of the walk.
	always_ff @(posedge clk) begin
		i_q     <= i_d;
		j_q     <= j_d;
		x_q     <= x_d;
		tgt_q   <= tgt_d;
		pend_q  <= pend_d;
		row_q   <= row_d;
		rep_q   <= rep_d;
		reach_q <= reach_d;
		front_q <= front_d;
		ph2_q   <= ph2_d;
		found_q <= found_d;
		k_q     <= k_d;
	end

	// Next state, memory requests and result fields.
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		x_d     = x_q;
		tgt_d   = tgt_q;
		pend_d  = pend_q;
		row_d   = row_q;
		rep_d   = rep_q;
		reach_d = reach_q;
		front_d = front_q;
		ph2_d   = ph2_q;
		found_d = found_q;
		k_d     = k_q;

		adj_req    = '0;
		list_we    = 1'b0;
		list_re    = 1'b0;
		list_raddr = k_q;
		bfs_done   = 1'b0;
		bfs_hit    = 1'b0;
		jn         = gbf_pkg::lowest_bit(pend_q);
		xn         = gbf_pkg::lowest_bit(front_q);
		nb         = '0;

		out_valid    = 1'b0;
		is_bridge    = 1'b0;
		bridge_count = '0;
		end_a        = '0;
		end_b        = '0;
		last         = 1'b0;

		unique case (state_q)
			gbf_pkg::S_IDLE: begin
				if (start) begin
					i_d     = '0;
					found_d = '0;
					state_d = gbf_pkg::S_ROW_RD;
				end
			end
			gbf_pkg::S_ROW_RD: begin
				if (i_q >= n_eff) begin
					state_d = gbf_pkg::S_OUT_CNT;
				end else begin
					adj_req.re    = 1'b1;
					adj_req.raddr = i_idx;
					rep_d         = '0;
					state_d       = gbf_pkg::S_ROW_WT;
				end
			end
			gbf_pkg::S_ROW_WT: begin
				row_d   = adj_rdata[N-1:0];
				pend_d  = row_m;
				state_d = gbf_pkg::S_PICK;
			end
			gbf_pkg::S_PICK: begin
				if (pend_q == '0) begin
					// Row done: store the pairs reported from this row.
					adj_req.we    = 1'b1;
					adj_req.waddr = i_idx;
					adj_req.wdata = {rep_q, row_q};
					i_d           = i_q + 1'b1;
					state_d       = gbf_pkg::S_ROW_RD;
				end else begin
					pend_d = pend_q & ~(N'(1) << jn);
					j_d    = jn;
					if (jn == i_idx) begin
						state_d = gbf_pkg::S_PICK;
					end else if (jn < i_idx) begin
						adj_req.re    = 1'b1;
						adj_req.raddr = jn;
						state_d       = gbf_pkg::S_REP;
					end else begin
						reach_d = N'(1) << jn;
						front_d = N'(1) << jn;
						tgt_d   = i_idx;
						ph2_d   = 1'b0;
						state_d = gbf_pkg::S_BFS_SEL;
					end
				end
			end
			gbf_pkg::S_REP: begin
				// Skip an edge whose mirror was already reported.
				if (adj_rdata[N + int'(i_idx)]) begin
					state_d = gbf_pkg::S_PICK;
				end else begin
					reach_d = N'(1) << j_q;
					front_d = N'(1) << j_q;
					tgt_d   = i_idx;
					ph2_d   = 1'b0;
					state_d = gbf_pkg::S_BFS_SEL;
				end
			end
			gbf_pkg::S_BFS_SEL: begin
				if (reach_q[tgt_q]) begin
					bfs_done = 1'b1;
					bfs_hit  = 1'b1;
				end else if (front_q == '0) begin
					bfs_done = 1'b1;
				end else begin
					front_d       = front_q & ~(N'(1) << xn);
					x_d           = xn;
					adj_req.re    = 1'b1;
					adj_req.raddr = xn;
					state_d       = gbf_pkg::S_BFS_MRG;
				end
			end
			gbf_pkg::S_BFS_MRG: begin
				nb = row_m;
				if (ph2_q && x_q == i_idx) begin
					nb[j_q] = 1'b0;
				end
				nb      = nb & ~reach_q;
				reach_d = reach_q | nb;
				front_d = front_q | nb;
				state_d = gbf_pkg::S_BFS_SEL;
			end
			gbf_pkg::S_OUT_CNT: begin
				out_valid    = 1'b1;
				bridge_count = found_q;
				last         = (found_q == '0);
				if (out_ready) begin
					if (found_q == '0) begin
						state_d = gbf_pkg::S_IDLE;
					end else begin
						k_d        = '0;
						list_re    = 1'b1;
						list_raddr = '0;
						state_d    = gbf_pkg::S_OUT_BR;
					end
				end
			end
			gbf_pkg::S_OUT_BR: begin
				out_valid = 1'b1;
				is_bridge = 1'b1;
				end_a     = list_rdata[2*IW-1:IW];
				end_b     = list_rdata[IW-1:0];
				last      = br_last;
				if (out_ready) begin
					if (br_last) begin
						state_d = gbf_pkg::S_IDLE;
					end else begin
						k_d        = k_q + 1'b1;
						list_re    = 1'b1;
						list_raddr = k_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = gbf_pkg::S_IDLE;
			end
		endcase

		// End of a reachability sweep. The first sweep asks whether the far
		// end reaches back to the row node; the second whether the row node
		// still reaches the far end without the edge under test.
		if (bfs_done) begin
			if (!ph2_q) begin
				if (bfs_hit) begin
					reach_d = N'(1) << i_idx;
					front_d = N'(1) << i_idx;
					tgt_d   = j_q;
					ph2_d   = 1'b1;
					state_d = gbf_pkg::S_BFS_SEL;
				end else begin
					state_d = gbf_pkg::S_PICK;
				end
			end else if (bfs_hit) begin
				state_d = gbf_pkg::S_PICK;
			end else begin
				list_we     = 1'b1;
				found_d     = found_q + 1'b1;
				rep_d[j_q]  = 1'b1;
				if (found_q == BW'(gbf_pkg::BRIDGE_LIMIT - 1)) begin
					state_d = gbf_pkg::S_OUT_CNT;
				end else begin
					state_d = gbf_pkg::S_PICK;
				end
			end
		end
	end

	assign busy = (state_q != gbf_pkg::S_IDLE);

endmodule

[sv/graph_bridge_finder.sv]
// Top level of the graph bridge finder: transaction intake, node count
// register, adjacency memory with its load path, and the search sequencer.
// Depends on gbf_pkg, gbf_ram and gbf_search.

// Clear and add transactions are taken one per cycle; an add is a
// read-modify-write of one adjacency row, with the row forwarded when the
// next add hits it. A run transaction holds intake off until its last result
// has been taken. The run visits each edge (i, j) among the nodes in use and
// decides it with up to two reachability sweeps over the adjacency memory;
// a self loop is passed over without a sweep, and so is an edge whose
// mirror was already reported. The results are then delivered one per
// cycle while out_ready is high. At most 63 bridges are listed.
module graph_bridge_finder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [gbf_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                opcode,
	input  logic [gbf_pkg::IDX_W-1:0] node,
	input  logic [gbf_pkg::IDX_W-1:0] neighbor,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      is_bridge,
	output logic [gbf_pkg::BR_W-1:0]  bridge_count,
	output logic [gbf_pkg::IDX_W-1:0] end_a,
	output logic [gbf_pkg::IDX_W-1:0] end_b,
	output logic                      last
);

	localparam int N  = gbf_pkg::MAX_NODES;
	localparam int IW = gbf_pkg::IDX_W;
	localparam int RW = gbf_pkg::ROW_W;

	logic [gbf_pkg::CNT_W-1:0] node_count_q, n_eff;
	logic in_acc, clr_acc, add_acc, run_acc, busy;

	gbf_pkg::adj_req_t srch_req, mem_req;
	logic [RW-1:0] adj_rdata, adj_eff, ld_base, ld_wdata;
	logic [N-1:0]  row_valid_q;
	logic          rd_ok_q;

	logic          ld_v_s1;
	logic [IW-1:0] ld_row_s1, ld_col_s1;
	logic          lw_v_q;
	logic [IW-1:0] lw_row_q;
	logic [RW-1:0] lw_data_q;

	assign in_ready = !busy;
	assign in_acc   = in_valid && in_ready;
	assign clr_acc  = in_acc && (opcode == gbf_pkg::OP_CLEAR);
	assign add_acc  = in_acc && (opcode == gbf_pkg::OP_ADD);
	assign run_acc  = in_acc && (opcode == gbf_pkg::OP_RUN);

	assign n_eff = (node_count_q > gbf_pkg::CNT_W'(N)) ? gbf_pkg::CNT_W'(N) : node_count_q;

	// Node count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	// Load path: merge the new bit into the row read at acceptance, taking the
	// row from the last write when that write went to the same row.
	assign ld_base  = (lw_v_q && lw_row_q == ld_row_s1) ? lw_data_q : adj_eff;
	assign ld_wdata = ld_base | RW'(N'(1) << ld_col_s1);

	// Memory port sharing: the loader owns the port while no run is active.
	always_comb begin
		mem_req = srch_req;
		if (!busy) begin
			mem_req.re    = add_acc;
			mem_req.raddr = node;
		end
		if (ld_v_s1) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = ld_row_s1;
			mem_req.wdata = ld_wdata;
		end
	end

	// A row never written since the last clear reads as zero.
	assign adj_eff = rd_ok_q ? adj_rdata : '0;

	gbf_ram #(
		.WIDTH(RW),
		.DEPTH(N)
	) u_adj (
		.clk  (clk),
		.we   (mem_req.we),
		.waddr(mem_req.waddr),
		.wdata(mem_req.wdata),
		.re   (mem_req.re),
		.raddr(mem_req.raddr),
		.rdata(adj_rdata)
	);

	// Row valid bits and load control; a clear wins over a write in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			ld_v_s1     <= 1'b0;
			lw_v_q      <= 1'b0;
		end else begin
			if (clr_acc) begin
				row_valid_q <= '0;
			end else if (mem_req.we) begin
				row_valid_q[mem_req.waddr] <= 1'b1;
			end
			ld_v_s1 <= add_acc;
			if (clr_acc || run_acc) begin
				lw_v_q <= 1'b0;
			end else if (ld_v_s1) begin
				lw_v_q <= 1'b1;
			end
		end
	end

	// Load payload and read qualifier.
	always_ff @(posedge clk) begin
		if (add_acc) begin
			ld_row_s1 <= node;
			ld_col_s1 <= neighbor;
		end
		if (ld_v_s1) begin
			lw_row_q  <= ld_row_s1;
			lw_data_q <= ld_wdata;
		end
		if (mem_req.re) begin
			rd_ok_q <= row_valid_q[mem_req.raddr];
		end
	end

	gbf_search u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (run_acc),
		.n_eff       (n_eff),
		.adj_req     (srch_req),
		.adj_rdata   (adj_eff),
		.busy        (busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_bridge   (is_bridge),
		.bridge_count(bridge_count),
		.end_a       (end_a),
		.end_b       (end_b),
		.last        (last)
	);

endmodule

[tb/graph_bridge_finder_tb.sv]
// Self-checking testbench for graph_bridge_finder: a directed table followed by
// random graphs, with every result checked against a bridge predictor in the bench.
// Depends on gbf_pkg and the graph_bridge_finder RTL.
`timescale 1ns / 100ps

module graph_bridge_finder_tb;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 40000;

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [1:0] op;
		int a;
		int b;
		int exp_cnt;
	} dir_row_t;

	typedef struct {
		bit is_b;
		bit [5:0] cnt;
		bit [5:0] ea;
		bit [5:0] eb;
		bit lst;
	} bridge_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [gbf_pkg::CNT_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = gbf_pkg::OP_CLEAR;
	logic [gbf_pkg::IDX_W-1:0] node = '0;
	logic [gbf_pkg::IDX_W-1:0] neighbor = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic is_bridge;
	logic [gbf_pkg::BR_W-1:0] bridge_count;
	logic [gbf_pkg::IDX_W-1:0] end_a;
	logic [gbf_pkg::IDX_W-1:0] end_b;
	logic last;

	// Bench copy of the block state.
	logic [63:0] graph_rows [64];
	int node_limit = 0;
	bridge_res_t pending_results [$];

	int snd_idle = 15;
	int rcv_idle = 81;
	int hold_ask = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int items_sent = 0;
	int searches = 0;
	int bridges_seen = 0;
	int big_graphs = 0;

	dir_row_t dir_rows [0:23] = '{
		'{ROW_ITEM, gbf_pkg::OP_RUN, 0, 0, 0},
		'{ROW_CFG, gbf_pkg::OP_CLEAR, 4, 0, -1},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 0, 1, -1},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 1, 0, -1},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 1, 2, -1},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 2, 1, -1},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 2, 2, -1},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 63, 63, -1},
		'{ROW_ITEM, OP_NOP, 63, 63, -1},
		'{ROW_ITEM, gbf_pkg::OP_RUN, 0, 0, 2},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 2, 0, -1},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 0, 2, -1},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 0, 1, -1},
		'{ROW_ITEM, gbf_pkg::OP_RUN, 0, 0, 0},
		'{ROW_ITEM, gbf_pkg::OP_CLEAR, 0, 0, -1},
		'{ROW_ITEM, gbf_pkg::OP_RUN, 0, 0, 0},
		'{ROW_CFG, gbf_pkg::OP_CLEAR, 127, 0, -1},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 62, 63, -1},
		'{ROW_ITEM, gbf_pkg::OP_ADD, 63, 62, -1},
		'{ROW_ITEM, gbf_pkg::OP_RUN, 0, 0, 1},
		'{ROW_CFG, gbf_pkg::OP_CLEAR, 1, 0, -1},
		'{ROW_ITEM, gbf_pkg::OP_RUN, 0, 0, 0},
		'{ROW_CFG, gbf_pkg::OP_CLEAR, 64, 0, -1},
		'{ROW_ITEM, gbf_pkg::OP_RUN, 0, 0, 1}
	};

	graph_bridge_finder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.node(node),
		.neighbor(neighbor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_bridge(is_bridge),
		.bridge_count(bridge_count),
		.end_a(end_a),
		.end_b(end_b),
		.last(last)
	);

	always #5 clk = ~clk;

	// Strongly connected components among nodes below n, optionally without one bit.
	function automatic int count_components(int n, bit skip, int su, int sv);
		int vis [64];
		int low [64];
		int wpos [64];
		int nstk [64];
		int cstk [64];
		bit onst [64];
		int comps;
		int nid;
		int nsp;
		int csp;
		int u;
		int w;
		int x;
		int p;
		comps = 0;
		nid = 1;
		nsp = 0;
		csp = 0;
		for (int s = 0; s < n; s++) begin
			vis[s] = 0;
			onst[s] = 0;
		end
		for (int s = 0; s < n; s++) begin
			if (vis[s] != 0)
				continue;
			vis[s] = nid;
			low[s] = nid;
			nid++;
			wpos[s] = 0;
			nstk[nsp++] = s;
			onst[s] = 1;
			cstk[csp++] = s;
			while (csp > 0) begin
				u = cstk[csp - 1];
				if (wpos[u] < n) begin
					w = wpos[u];
					wpos[u]++;
					if (!graph_rows[u][w])
						continue;
					if (skip && u == su && w == sv)
						continue;
					if (vis[w] == 0) begin
						vis[w] = nid;
						low[w] = nid;
						nid++;
						wpos[w] = 0;
						nstk[nsp++] = w;
						onst[w] = 1;
						cstk[csp++] = w;
					end else if (onst[w] && vis[w] < low[u]) begin
						low[u] = vis[w];
					end
				end else begin
					if (low[u] == vis[u]) begin
						do begin
							nsp--;
							x = nstk[nsp];
							onst[x] = 0;
						end while (x != u && nsp > 0);
						comps++;
					end
					csp--;
					if (csp > 0) begin
						p = cstk[csp - 1];
						if (low[u] < low[p])
							low[p] = low[u];
					end
				end
			end
		end
		return comps;
	endfunction

	// Queues the count result and the bridge list of one search; returns the count.
	function automatic int predict_bridges();
		logic [63:0] reported [64];
		bridge_res_t found_list [$];
		bridge_res_t r;
		int n;
		int base;
		n = (node_limit > gbf_pkg::MAX_NODES) ? gbf_pkg::MAX_NODES : node_limit;
		for (int k = 0; k < 64; k++)
			reported[k] = '0;
		base = count_components(n, 0, 0, 0);
		for (int i = 0; i < n && found_list.size() < gbf_pkg::BRIDGE_LIMIT; i++) begin
			for (int j = 0; j < n && found_list.size() < gbf_pkg::BRIDGE_LIMIT; j++) begin
				if (!graph_rows[i][j] || reported[j][i])
					continue;
				if (count_components(n, 1, i, j) != base) begin
					reported[i][j] = 1'b1;
					r = '{1'b1, 6'd0, 6'(i), 6'(j), 1'b0};
					found_list = {found_list, r};
				end
			end
		end
		r = '{1'b0, 6'(found_list.size()), 6'd0, 6'd0, found_list.size() == 0};
		pending_results = {pending_results, r};
		foreach (found_list[k]) begin
			r = found_list[k];
			r.lst = (k == found_list.size() - 1);
			pending_results = {pending_results, r};
		end
		return found_list.size();
	endfunction

	// Offers one transaction after a random gap and updates the bench state once taken.
	task automatic send_item(logic [1:0] op, int a, int b, int exp_cnt);
		int cnt;
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		node <= 6'(a);
		neighbor <= 6'(b);
		do
			@(posedge clk);
		while (!in_ready);
		case (op)
			gbf_pkg::OP_CLEAR: begin
				for (int k = 0; k < 64; k++)
					graph_rows[k] = '0;
			end
			gbf_pkg::OP_ADD: begin
				graph_rows[a][b] = 1'b1;
			end
			gbf_pkg::OP_RUN: begin
				cnt = predict_bridges();
				searches++;
				if (exp_cnt >= 0 && cnt != exp_cnt) begin
					$display("%0t: bridge count expected %0d, predicted %0d", $time,
						exp_cnt, cnt);
					errors++;
				end
			end
			default: begin
			end
		endcase
		if (op != OP_NOP)
			items_sent++;
	endtask

	// Waits for every result to drain, then writes the node count.
	task automatic write_node_count(int value);
		in_valid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= 7'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		node_limit = value;
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// Result checker: each transaction against the oldest expectation.
	always @(posedge clk) begin
		bridge_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result is_bridge=%0d count=%0d ends=%0d,%0d last=%0d",
					$time, is_bridge, bridge_count, end_a, end_b, last);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (e.is_b) bridges_seen++;
				if (is_bridge !== e.is_b || bridge_count !== e.cnt || end_a !== e.ea ||
						end_b !== e.eb || last !== e.lst) begin
					$display("%0t: expected is_bridge=%0d count=%0d ends=%0d,%0d last=%0d",
						$time, e.is_b, e.cnt, e.ea, e.eb, e.lst);
					$display("%0t: actual   is_bridge=%0d count=%0d ends=%0d,%0d last=%0d",
						$time, is_bridge, bridge_count, end_a, end_b, last);
					errors++;
				end
			end
		end
	end

	// Watchdog for a hung run.
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// Main stimulus sequence.
	initial begin
		int n;
		int edges;
		int a;
		int b;
		int phase;
		int wait_cycles;
		for (int k = 0; k < 64; k++)
			graph_rows[k] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG)
				write_node_count(dir_rows[r].a);
			else
				send_item(dir_rows[r].op, dir_rows[r].a, dir_rows[r].b, dir_rows[r].exp_cnt);
		end

		// Random graphs, one or more searches per phase.
		phase = 0;
		while (items_sent < 400) begin
			if (items_sent < 170) begin
				snd_idle = 15;
				rcv_idle = 81;
			end else if (items_sent < 310) begin
				snd_idle = 81;
				rcv_idle = 15;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			case ($urandom_range(9))
				0: n = (big_graphs < 2) ? 64 : 8;
				1: n = 127;
				2: n = $urandom_range(1);
				default: n = $urandom_range(12, 2);
			endcase
			write_node_count(n);
			if (n >= 64 || $urandom_range(3) != 0)
				send_item(gbf_pkg::OP_CLEAR, $urandom_range(63), $urandom_range(63), -1);
			if (n == 64) begin
				// Long path over every node: the bridge list is at its largest.
				big_graphs++;
				for (int k = 0; k < 63; k++) begin
					send_item(gbf_pkg::OP_ADD, k, k + 1, -1);
					send_item(gbf_pkg::OP_ADD, k + 1, k, -1);
				end
			end else begin
				edges = (n > 64) ? 10 : $urandom_range(2 * n + 1);
				for (int k = 0; k < edges; k++) begin
					a = $urandom_range((n > 64 ? 64 : (n < 1 ? 1 : n)) - 1);
					b = $urandom_range((n > 64 ? 64 : (n < 1 ? 1 : n)) - 1);
					case ($urandom_range(19))
						0: send_item(gbf_pkg::OP_ADD, $urandom_range(63), $urandom_range(63),
							-1);
						1: send_item(OP_NOP, $urandom_range(63), $urandom_range(63), -1);
						2: send_item(gbf_pkg::OP_ADD, a, b, -1);
						default: begin
							send_item(gbf_pkg::OP_ADD, a, b, -1);
							send_item(gbf_pkg::OP_ADD, b, a, -1);
						end
					endcase
				end
			end
			if (phase == 3) begin
				// Hold the receiver off and keep offering so intake backs up.
				hold_ask++;
				send_item(gbf_pkg::OP_RUN, 0, 0, -1);
				for (int k = 0; k < 3; k++)
					send_item(gbf_pkg::OP_ADD, $urandom_range(63), $urandom_range(63), -1);
			end
			send_item(gbf_pkg::OP_RUN, 0, 0, -1);
			if ($urandom_range(5) == 0)
				send_item(gbf_pkg::OP_RUN, 0, 0, -1);
			phase++;
		end

		// Drain.
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (pending_results.size() > 0 && wait_cycles < 500000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() > 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			errors++;
		end
		$display("Covered %0d transactions, %0d searches, %0d bridges reported.",
			items_sent, searches, bridges_seen);
		$display("Node counts from zero to the register maximum, with sender and receiver stalls.");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
